FILE: sv/cfgpf_pkg.sv
// shared types and constants for the configuration packet idcode finder
// no dependencies; imported by cfgpf_step, the top level and the testbench
package cfgpf_pkg;

    localparam logic [31:0] SYNC_WORD  = 32'hAA99_5566;
    localparam logic [4:0]  IDCODE_REG = 5'h0C;
    localparam logic [1:0]  OP_WRITE   = 2'd2;
    localparam logic [2:0]  PT_TYPE1   = 3'd1;
    localparam logic [2:0]  PT_TYPE2   = 3'd2;
    localparam int          CNT_W      = 27;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_PARSE = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_SYNC   = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_phase             phase;
        logic [1:0]         operation;
        logic [4:0]         reg_address;
        logic [CNT_W-1:0]   packet_words;
        logic [CNT_W-1:0]   words_left;
    } t_state;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] idcode;
    } t_result;

    localparam t_state STATE_CLEAR = '{
        phase:        PH_HUNT,
        operation:    2'd0,
        reg_address:  5'd0,
        packet_words: '0,
        words_left:   '0
    };

endpackage

FILE: sv/cfgpf_step.sv
// next-state and result logic for one stream word
// depends on cfgpf_pkg
module cfgpf_step
    import cfgpf_pkg::*;
(
    input  t_state      i_state,
    input  logic [31:0] i_word,
    input  logic        i_last,
    output t_state      o_state,
    output t_result     o_result
);

    logic [2:0] ptype;
    logic       bad_type;
    logic       found;

    assign ptype = i_word[31:29];

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, status: ST_FOUND, idcode: 32'd0};
        bad_type = 1'b0;
        found    = 1'b0;
        case (i_state.phase)
            PH_HUNT: begin
                if (i_word == SYNC_WORD) begin
                    o_state = STATE_CLEAR;
                    if (i_last) begin
                        o_result.valid  = 1'b1;
                        o_result.status = ST_NOT_FOUND;
                    end else begin
                        o_state.phase = PH_PARSE;
                    end
                end else if (i_last) begin
                    o_state         = STATE_CLEAR;
                    o_result.valid  = 1'b1;
                    o_result.status = ST_NO_SYNC;
                end
            end
            PH_PARSE: begin
                if (i_state.words_left == '0) begin
                    // header expected
                    if (ptype == PT_TYPE1) begin
                        o_state.operation    = i_word[28:27];
                        o_state.reg_address  = i_word[17:13];
                        o_state.packet_words = {{(CNT_W-11){1'b0}}, i_word[10:0]};
                        o_state.words_left   = {{(CNT_W-11){1'b0}}, i_word[10:0]};
                    end else if (ptype == PT_TYPE2) begin
                        o_state.operation    = i_word[28:27];
                        o_state.packet_words = i_word[CNT_W-1:0];
                        o_state.words_left   = i_word[CNT_W-1:0];
                    end else begin
                        bad_type = 1'b1;
                    end
                end else begin
                    o_state.words_left = i_state.words_left - CNT_W'(1);
                    found = (i_state.operation == OP_WRITE) &&
                            (i_state.reg_address == IDCODE_REG) &&
                            (i_state.packet_words == CNT_W'(1));
                end
                if (bad_type || found || i_last) begin
                    o_result.valid = 1'b1;
                    if (bad_type) begin
                        o_result.status = ST_BAD_TYPE;
                    end else if (found) begin
                        o_result.status = ST_FOUND;
                        o_result.idcode = i_word;
                    end else begin
                        o_result.status = ST_NOT_FOUND;
                    end
                    if (i_last) begin
                        o_state = STATE_CLEAR;
                    end else begin
                        o_state.phase = PH_DONE;
                    end
                end
            end
            default: begin
                // result given, skip to the end of the stream
                if (i_last) begin
                    o_state = STATE_CLEAR;
                end
            end
        endcase
    end

endmodule

FILE: sv/config_packet_idcode_finder.sv
// top level: parser state register, output register and stream handshakes
// depends on cfgpf_pkg and cfgpf_step
//
// Scans a configuration stream for the sync word, then walks the packet
// headers and reports the IDCODE written by a one-word write to register 0x0C.
// Slave side: one beat per stream word, i_s_tdata holds the word and
// i_s_tlast marks the last word of the stream.
// Master side: at most one beat per stream; o_m_tuser carries the status
// (found, no sync, unknown packet type, not found) and o_m_tdata the IDCODE,
// zero for any status but found.
// A result is registered and appears on the master side in the cycle after the word
// that causes it is taken. The slave side takes one word per cycle while no held
// result stalls it, set by the single register stage around the header decode.
// After a result the block drops words up to and including the last-word
// beat, then hunts for sync again; a last word always rearms it.
// Reset (synchronous, active low) returns the parser to sync hunting and
// empties the output register.
// When the receiver stalls, the held result blocks new words only if the
// output register is full and not being drained in the same cycle.
module config_packet_idcode_finder
    import cfgpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] word
    input  logic        i_s_tlast,   // last_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] idcode
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    t_state      r_state;
    t_state      n_state;
    t_result     step_res;
    logic        r_m_valid;
    t_status     r_m_status;
    logic [31:0] r_m_idcode;
    logic        s_accept;

    cfgpf_step u_step (
        .i_state  (r_state),
        .i_word   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= STATE_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state <= n_state;
            end
            if (s_accept && step_res.valid) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && step_res.valid) begin
            r_m_status <= step_res.status;
            r_m_idcode <= step_res.idcode;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_idcode;
    assign o_m_tuser  = r_m_status;

    a_idcode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_FOUND) |-> (o_m_tdata == 32'd0))
        else $error("idcode not zero on a non-found result");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_state == STATE_CLEAR))
        else $error("parser not rearmed after last word");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && step_res.valid && !i_s_tlast) |=> (r_state.phase == PH_DONE))
        else $error("parser not waiting for last word after result");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_HUNT) |-> (r_state.words_left == '0))
        else $error("word count left over while hunting");

    a_result_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && step_res.valid) |=> o_m_tvalid)
        else $error("result lost");

endmodule

FILE: test/tb_config_packet_idcode_finder.sv
// testbench for config_packet_idcode_finder: drives configuration streams and
// checks every status/idcode beat against a predictor of the packet parser
// depends on cfgpf_pkg and the config_packet_idcode_finder rtl
module tb_config_packet_idcode_finder;
    import cfgpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] idcode;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;    // [31:0] word
    logic        i_s_tlast = 1'b0;  // last_word
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] idcode
    logic [1:0]  o_m_tuser;         // [1:0] status

    t_beat   pending_beats[$];
    t_report expected_reports[$];
    int      error_count = 0;

    // parser state of the predictor
    t_phase           parse_phase;
    logic [1:0]       pkt_op;
    logic [4:0]       pkt_addr;
    logic [CNT_W-1:0] pkt_count;
    logic [CNT_W-1:0] words_due;

    // sender and receiver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [5:0]  pattern_pos = '0;

    config_packet_idcode_finder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function void clear_parser();
        parse_phase = PH_HUNT;
        pkt_op      = '0;
        pkt_addr    = '0;
        pkt_count   = '0;
        words_due   = '0;
    endfunction

    function void report_status(input t_status st, input logic [31:0] id, input logic last);
        t_report r;
        r.status = st;
        r.idcode = id;
        expected_reports = {expected_reports, r};
        if (last)
            clear_parser();
        else
            parse_phase = PH_DONE;
    endfunction

    function void parse_word(input logic [31:0] w, input logic last);
        logic [2:0] ptype;
        ptype = w[31:29];
        case (parse_phase)
            PH_HUNT: begin
                if (w == SYNC_WORD) begin
                    clear_parser();
                    if (last)
                        report_status(ST_NOT_FOUND, '0, 1'b1);
                    else
                        parse_phase = PH_PARSE;
                end else if (last) begin
                    report_status(ST_NO_SYNC, '0, 1'b1);
                end
            end
            PH_PARSE: begin
                if (words_due == '0) begin
                    if (ptype == PT_TYPE1) begin
                        pkt_op    = w[28:27];
                        pkt_addr  = w[17:13];
                        pkt_count = CNT_W'(w[10:0]);
                        words_due = pkt_count;
                    end else if (ptype == PT_TYPE2) begin
                        // type-2 keeps the address of the previous header
                        pkt_op    = w[28:27];
                        pkt_count = w[26:0];
                        words_due = pkt_count;
                    end else begin
                        report_status(ST_BAD_TYPE, '0, last);
                        return;
                    end
                end else begin
                    words_due = words_due - CNT_W'(1);
                    if (pkt_op == OP_WRITE && pkt_addr == IDCODE_REG &&
                        pkt_count == CNT_W'(1)) begin
                        report_status(ST_FOUND, w, last);
                        return;
                    end
                end
                if (last)
                    report_status(ST_NOT_FOUND, '0, 1'b1);
            end
            default: begin
                // result already given: drop words until the last-word beat
                if (last)
                    clear_parser();
            end
        endcase
    endfunction

    function logic [31:0] type1_header(input logic [1:0] op, input logic [4:0] addr,
                                       input logic [10:0] count);
        return {PT_TYPE1, op, 9'($urandom), addr, 2'($urandom), count};
    endfunction

    function logic [31:0] type2_header(input logic [1:0] op, input logic [26:0] count);
        return {PT_TYPE2, op, count};
    endfunction

    function logic [31:0] bad_header();
        logic [2:0] ptype;
        ptype = 3'($urandom);
        while (ptype == PT_TYPE1 || ptype == PT_TYPE2)
            ptype = 3'($urandom);
        return {ptype, 29'($urandom)};
    endfunction

    task automatic push_beat(input logic [31:0] w, input logic last);
        t_beat b;
        b.word = w;
        b.last = last;
        pending_beats = {pending_beats, b};
    endtask

    // one stream of random content; last is set on its final word
    task automatic add_random_stream();
        logic [31:0] words[$];
        int          kind;
        int          sel;
        int          n;
        logic [4:0]  addr;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n = $urandom_range(0, 3);
            repeat (n) words = {words, 32'($urandom)};
            words = {words, SYNC_WORD};
            n = $urandom_range(0, 4);
            for (int p = 0; p < n; p++) begin
                sel = $urandom_range(0, 9);
                if (sel <= 2) begin
                    if ($urandom_range(0, 2) == 0) begin
                        words = {words, type1_header(OP_WRITE, IDCODE_REG, 11'd0)};
                        words = {words, type2_header(OP_WRITE, 27'd1)};
                    end else begin
                        words = {words, type1_header(OP_WRITE, IDCODE_REG, 11'd1)};
                    end
                    words = {words, 32'($urandom)};
                end else if (sel <= 5) begin
                    addr = $urandom_range(0, 1) ? IDCODE_REG : 5'($urandom);
                    sel = $urandom_range(0, 3);
                    words = {words, type1_header(2'($urandom), addr, 11'(sel))};
                    repeat (sel) words = {words, 32'($urandom)};
                end else if (sel <= 7) begin
                    sel = $urandom_range(0, 3);
                    words = {words, type2_header(2'($urandom), 27'(sel))};
                    repeat (sel) words = {words, 32'($urandom)};
                end else if (sel == 8) begin
                    // long packet of random count, the last packet: the stream usually ends inside its data
                    if ($urandom_range(0, 1))
                        words = {words, type1_header(2'($urandom), 5'($urandom),
                                                     11'($urandom))};
                    else
                        words = {words, type2_header(2'($urandom), 27'($urandom))};
                    repeat ($urandom_range(0, 3)) words = {words, 32'($urandom)};
                    break;
                end else begin
                    words = {words, bad_header()};
                end
            end
            repeat ($urandom_range(0, 2)) words = {words, 32'($urandom)};
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) words = {words, 32'($urandom)};
        end else begin
            words = {words, SYNC_WORD};
            repeat ($urandom_range(1, 4)) words = {words, 32'($urandom)};
        end
        foreach (words[i])
            push_beat(words[i], i == words.size() - 1);
    endtask

    // stream sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tlast  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                b = pending_beats.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= b.word;
                i_s_tlast  <= b.last;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready follows a 16-bit pattern, picked afresh each time the 6-bit position counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            pattern_pos = '0;
        end else begin
            if (pattern_pos == '0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'h8000;
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            i_m_tready <= ready_pattern[pattern_pos[3:0]];
            pattern_pos = pattern_pos + 1'b1;
        end
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge i_clk) begin
        t_report r;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_s_tvalid && o_s_tready)
                parse_word(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result with no expectation: status %0d idcode %h",
                           o_m_tuser, o_m_tdata);
                    error_count++;
                end else begin
                    r = expected_reports.pop_front();
                    if (o_m_tuser !== r.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               r.status, o_m_tuser);
                        error_count++;
                    end
                    if (o_m_tdata !== r.idcode) begin
                        $error("idcode mismatch: expected %h, actual %h",
                               r.idcode, o_m_tdata);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        // no sync: stream ends while hunting, a near-sync word included
        push_beat(32'h0000_0000, 1'b1);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'hAA99_5567, 1'b1);
        // sync word is the last word
        push_beat(SYNC_WORD, 1'b1);
        // idcode on the last word
        push_beat(SYNC_WORD, 1'b0);
        push_beat(type1_header(OP_WRITE, IDCODE_REG, 11'd1), 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1);
        // zero-count header, then idcode before the last word, then ignored words
        push_beat(SYNC_WORD, 1'b0);
        push_beat(type1_header(2'd0, 5'd0, 11'd0), 1'b0);
        push_beat(type1_header(OP_WRITE, IDCODE_REG, 11'd1), 1'b0);
        push_beat(32'h0000_0000, 1'b0);
        push_beat(SYNC_WORD, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1);
        // type-2 write keeps the idcode address of the type-1 header
        push_beat(SYNC_WORD, 1'b0);
        push_beat(type1_header(OP_WRITE, IDCODE_REG, 11'd0), 1'b0);
        push_beat(type2_header(OP_WRITE, 27'd1), 1'b0);
        push_beat(32'h0362_D093, 1'b0);
        push_beat(32'h0000_0000, 1'b1);
        // unknown packet type on the last word
        push_beat(SYNC_WORD, 1'b0);
        push_beat(32'hE000_0000, 1'b1);
        // maximal type-2 count, stream ends inside the packet
        push_beat(SYNC_WORD, 1'b0);
        push_beat(type2_header(2'd3, 27'h7FF_FFFF), 1'b0);
        push_beat(32'h0000_0000, 1'b1);
        // two-word write to the idcode register is not reported
        push_beat(SYNC_WORD, 1'b0);
        push_beat(type1_header(OP_WRITE, IDCODE_REG, 11'd2), 1'b0);
        push_beat(32'h0000_0001, 1'b0);
        push_beat(32'h0000_0002, 1'b1);

        while (pending_beats.size() < 875)
            add_random_stream();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_beats.size() != 0 || i_s_tvalid || expected_reports.size() != 0);
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/cfgpf_pkg.sv
sv/cfgpf_step.sv
sv/config_packet_idcode_finder.sv
test/tb_config_packet_idcode_finder.sv
